FILE: rtl/core/rmsv_pkg.sv
// Shared types and constants for the running mean / sample variance core.
// No dependencies; imported by every module of the core.
package rmsv_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 16;
    localparam int SUM_W    = 32;
    localparam int SQSUM_W  = 47;
    localparam int MAG_W    = 31;
    localparam int VAR_W    = 32;
    localparam int DIV_W    = 64;
    localparam int DVS_W    = 32;
    localparam int DCNT_W   = 6;

    localparam logic [COUNT_W-1:0] MAX_RUN   = 16'd65535;
    localparam logic [DCNT_W-1:0]  DIV_LAST  = 6'd63;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_PREP,
        ST_MUL0,
        ST_MUL1,
        ST_COMB,
        ST_DIVM,
        ST_DIVV,
        ST_DONE
    } rmsv_state_t;

    typedef struct packed {
        logic acc;
        logic prep;
        logic mul0;
        logic mul1;
        logic comb;
        logic take_mean;
        logic div_var;
        logic take_var;
        logic finish;
    } rmsv_cmd_t;

    typedef struct packed {
        logic stats_ok;
        logic div_busy;
        logic out_busy;
    } rmsv_status_t;

endpackage

FILE: rtl/core/running_mean_sample_variance_core.sv
// Top level of the running mean / sample variance core.
// Depends on rmsv_pkg, rmsv_ctrl, rmsv_dp (and rmsv_div below it).
//
// Accepts one signed Q8.8 sample word per cycle while accumulating a run. On the word
// flagged last the input stalls while the result is formed: a single-sample run goes
// from PREP straight to DONE, a longer run steps through PREP, MUL0, MUL1 and COMB for
// the products, then two passes of the one-bit-per-cycle divider (mean, variance), then DONE.
// A finished result sits in an output register, so the next run's samples are taken
// while it waits; the run after that waits only if the result is still not taken.
module running_mean_sample_variance_core
    import rmsv_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       last,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [COUNT_W-1:0]         count,
    output logic signed [SAMPLE_W-1:0] mean,
    output logic [VAR_W-1:0]           variance,
    output logic                       stats_valid,
    output logic                       overflow
);

    rmsv_cmd_t    cmd;
    rmsv_status_t status;
    rmsv_state_t  state;

    rmsv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last     (last),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    rmsv_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .sample      (sample),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .count       (count),
        .mean        (mean),
        .variance    (variance),
        .stats_valid (stats_valid),
        .overflow    (overflow)
    );

    a_div_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_busy |-> in_stall && (state == ST_DIVM || state == ST_DIVV))
        else $error("divider running outside a division state");

    a_short_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !stats_valid |-> mean == '0 && variance == '0 && count < 16'd2)
        else $error("short run result not cleared");

    a_ovf_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> count == MAX_RUN)
        else $error("overflow flagged without saturated count");

    a_new_word: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state) == ST_DONE && state == ST_ACC)
        else $error("result word raised outside hand-off");

endmodule

FILE: rtl/core/rmsv_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
// Depends on rmsv_pkg.
module rmsv_div
    import rmsv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DVS_W-1:0]  divisor,
    output logic              busy,
    output logic [DIV_W-1:0]  quotient
);

    logic [DIV_W-1:0]  dq_reg, dq_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;

    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    rem_diff;
    logic              ge;

    assign rem_sh   = {rem_reg, dq_reg[DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};
    assign ge       = rem_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            dq_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = DIV_LAST;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            dq_next  = {dq_reg[DIV_W-2:0], ge};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = dq_reg;

endmodule

FILE: rtl/core/rmsv_dp.sv
// Datapath: accumulators, final products, shared divider and output word register.
// Depends on rmsv_pkg and rmsv_div.
module rmsv_dp
    import rmsv_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  rmsv_cmd_t                  cmd,
    output rmsv_status_t               status,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic [COUNT_W-1:0]         count,
    output logic signed [SAMPLE_W-1:0] mean,
    output logic [VAR_W-1:0]           variance,
    output logic                       stats_valid,
    output logic                       overflow
);

    logic [COUNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [SQSUM_W-1:0]        sq_reg, sq_next;
    logic                      ovf_reg, ovf_next;

    logic [MAG_W-1:0]          mag_reg;
    logic                      neg_reg;
    logic [39:0]               lo_prod_reg;
    logic [38:0]               hi_prod_reg;
    logic [61:0]               sqm_reg;
    logic [DVS_W-1:0]          nn1_reg;
    logic [62:0]               nq_reg;
    logic [SAMPLE_W-1:0]       mean_reg;
    logic [VAR_W-1:0]          var_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]        count_reg;
    logic [SAMPLE_W-1:0]       mean_out_reg;
    logic [VAR_W-1:0]          var_out_reg;
    logic                      stats_reg;
    logic                      ovf_out_reg;

    logic signed [31:0]        s_prod;
    logic [SUM_W-1:0]          mag_full;
    logic [62:0]               var_num;
    logic                      div_start;
    logic [DIV_W-1:0]          div_dividend;
    logic [DVS_W-1:0]          div_divisor;
    logic                      div_busy;
    logic [DIV_W-1:0]          div_q;
    logic                      stats_ok;

    assign s_prod   = 32'(sample) * 32'(sample);
    assign mag_full = sum_reg[SUM_W-1] ? (~sum_reg + 32'd1) : sum_reg;
    assign var_num  = nq_reg - {1'b0, sqm_reg};
    assign stats_ok = cnt_reg > 16'd1;

    always_comb
    begin
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        sq_next  = sq_reg;
        ovf_next = ovf_reg;
        if (cmd.finish)
        begin
            cnt_next = '0;
            sum_next = '0;
            sq_next  = '0;
            ovf_next = 1'b0;
        end
        else if (cmd.acc)
        begin
            if (cnt_reg < MAX_RUN)
            begin
                cnt_next = cnt_reg + 1'b1;
                sum_next = sum_reg + {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
                sq_next  = sq_reg + {{(SQSUM_W-32){1'b0}}, s_prod};
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            mag_reg <= mag_full[MAG_W-1:0];
            neg_reg <= sum_reg[SUM_W-1];
        end
        if (cmd.mul0)
        begin
            lo_prod_reg <= 40'(cnt_reg) * 40'(sq_reg[23:0]);
            sqm_reg     <= 62'(mag_reg) * 62'(mag_reg);
            nn1_reg     <= 32'(cnt_reg) * 32'(cnt_reg - 16'd1);
        end
        if (cmd.mul1)
        begin
            hi_prod_reg <= 39'(cnt_reg) * 39'(sq_reg[SQSUM_W-1:24]);
        end
        if (cmd.comb)
        begin
            nq_reg <= {hi_prod_reg, 24'd0} + {23'd0, lo_prod_reg};
        end
        if (cmd.take_mean)
        begin
            mean_reg <= neg_reg ? (~div_q[SAMPLE_W-1:0] + 16'd1) : div_q[SAMPLE_W-1:0];
        end
        if (cmd.take_var)
        begin
            var_reg <= (|div_q[DIV_W-1:VAR_W]) ? '1 : div_q[VAR_W-1:0];
        end
        if (cmd.finish)
        begin
            count_reg    <= cnt_reg;
            mean_out_reg <= stats_ok ? mean_reg : '0;
            var_out_reg  <= stats_ok ? var_reg : '0;
            stats_reg    <= stats_ok;
            ovf_out_reg  <= ovf_reg;
        end
    end

    // mean division starts with the combine step, variance as the mean is taken
    assign div_start    = cmd.comb | cmd.div_var;
    assign div_dividend = cmd.div_var ? {1'b0, var_num} : {{(DIV_W-MAG_W){1'b0}}, mag_reg};
    assign div_divisor  = cmd.div_var ? nn1_reg : {{(DVS_W-COUNT_W){1'b0}}, cnt_reg};

    rmsv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign status.stats_ok = stats_ok;
    assign status.div_busy = div_busy;
    assign status.out_busy = out_valid_reg & out_stall;

    assign out_valid   = out_valid_reg;
    assign count       = count_reg;
    assign mean        = mean_out_reg;
    assign variance    = var_out_reg;
    assign stats_valid = stats_reg;
    assign overflow    = ovf_out_reg;

endmodule

FILE: rtl/core/rmsv_ctrl.sv
// Controller: accumulate phase and the end-of-run sequence of products and divisions.
// Depends on rmsv_pkg.
module rmsv_ctrl
    import rmsv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         last,
    output logic         in_stall,
    input  rmsv_status_t status,
    output rmsv_cmd_t    cmd,
    output rmsv_state_t  state
);

    rmsv_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_ACC:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.acc = 1'b1;
                    if (last)
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = status.stats_ok ? ST_MUL0 : ST_DONE;
            end
            ST_MUL0:
            begin
                cmd.mul0   = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_COMB;
            end
            ST_COMB:
            begin
                cmd.comb   = 1'b1;
                state_next = ST_DIVM;
            end
            ST_DIVM:
            begin
                if (!status.div_busy)
                begin
                    cmd.take_mean = 1'b1;
                    cmd.div_var   = 1'b1;
                    state_next    = ST_DIVV;
                end
            end
            ST_DIVV:
            begin
                if (!status.div_busy)
                begin
                    cmd.take_var = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    assign state = state_reg;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for running_mean_sample_variance_core.
// Depends on rmsv_pkg and the core RTL. An in-bench predictor of count, mean and
// variance checks every result word, with random idling on both handshakes.
module testbench;
    import rmsv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 150;

    typedef struct packed {
        logic [COUNT_W-1:0]         count;
        logic signed [SAMPLE_W-1:0] mean;
        logic [VAR_W-1:0]           variance;
        logic                       stats_valid;
        logic                       overflow;
    } stats_word_t;

    typedef enum int {
        FILL_UNIFORM,
        FILL_SMALL,
        FILL_FLAT,
        FILL_RAIL,
        FILL_NOISY
    } fill_kind_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       out_valid;
    logic                       out_stall;
    logic [COUNT_W-1:0]         count;
    logic signed [SAMPLE_W-1:0] mean;
    logic [VAR_W-1:0]           variance;
    logic                       stats_valid;
    logic                       overflow;

    running_mean_sample_variance_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .count       (count),
        .mean        (mean),
        .variance    (variance),
        .stats_valid (stats_valid),
        .overflow    (overflow)
    );

    // predictor state
    int unsigned  acc_n;
    longint       acc_sum;
    logic [63:0]  acc_sq;
    bit           acc_ovf;
    stats_word_t  pending_stats[$];

    int  mismatches;
    bit  src_gaps_on;
    bit  sink_gaps_on;
    int  sink_hold_len;
    int  cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic flag_fail(input string what);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function automatic void fold_sample(input logic signed [SAMPLE_W-1:0] s, input logic l);
        longint      sv;
        longint      mag;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        stats_word_t r;
        sv = s;
        if (acc_n < MAX_RUN)
        begin
            acc_n++;
            acc_sum += sv;
            acc_sq += 64'(sv * sv);
        end
        else
        begin
            acc_ovf = 1'b1;
        end
        if (l)
        begin
            r = '0;
            r.count = (acc_n > 65535) ? 16'hFFFF : acc_n[COUNT_W-1:0];
            r.overflow = acc_ovf;
            if (acc_n > 1)
            begin
                r.stats_valid = 1'b1;
                r.mean = 16'(acc_sum / longint'(acc_n));
                mag = (acc_sum < 0) ? -acc_sum : acc_sum;
                num = 128'(acc_n) * 128'(acc_sq) - 128'(mag) * 128'(mag);
                den = 128'(acc_n) * 128'(acc_n - 1);
                quo = num / den;
                r.variance = (quo > 128'hFFFF_FFFF) ? '1 : quo[VAR_W-1:0];
            end
            pending_stats.push_back(r);
            acc_n = 0;
            acc_sum = 0;
            acc_sq = '0;
            acc_ovf = 1'b0;
        end
    endfunction

    task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic l);
        if (src_gaps_on && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        last <= l;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        fold_sample(s, l);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_stats.size() != 0);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input fill_kind_t kind,
                                                               input int base);
        int v;
        case (kind)
            FILL_UNIFORM: v = int'($urandom_range(0, 65535)) - 32768;
            FILL_SMALL:   v = int'($urandom_range(0, 510)) - 255;
            FILL_FLAT:    v = base;
            FILL_RAIL:
            begin
                case ($urandom_range(0, 2))
                    0:       v = 32767;
                    1:       v = -32768;
                    default: v = -32767;
                endcase
            end
            default:      v = base + int'($urandom_range(0, 30)) - 15;
        endcase
        if (v > 32767)
        begin
            v = 32767;
        end
        if (v < -32768)
        begin
            v = -32768;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic send_run(input int len, input fill_kind_t kind);
        int base;
        base = int'($urandom_range(0, 65535)) - 32768;
        for (int i = 0; i < len; i++)
        begin
            send_word(pick_sample(kind, base), i == len - 1);
        end
    endtask

    // single-word runs, extreme pairs, truncation of negative and positive means
    task automatic test_short_runs();
        int vals[16] = '{32767, -32768, 0, 32767, -32768, -32768, -32768, 32767,
                         32767, -1, -2, 1, 2, 256, -256, 257};
        bit ends[16] = '{1, 1, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 0, 1};
        for (int i = 0; i < 16; i++)
        begin
            send_word(vals[i][SAMPLE_W-1:0], ends[i]);
        end
    endtask

    // a long rail run and a long noisy run for wide sums, then a short run right behind them
    task automatic test_long_runs();
        src_gaps_on = 1'b0;
        send_run(200, FILL_RAIL);
        send_run(150, FILL_NOISY);
        send_word(16'sh0100, 1'b0);
        send_word(16'sh0300, 1'b1);
        src_gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        sink_hold_len = 600;
        for (int r = 0; r < 6; r++)
        begin
            send_run($urandom_range(1, 5), fill_kind_t'($urandom_range(0, 4)));
        end
        drain_results();
        for (int r = 0; r < 3; r++)
        begin
            send_run($urandom_range(2, 6), FILL_UNIFORM);
        end
    endtask

    task automatic test_random_runs(input int budget);
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                len = $urandom_range(1, 12);
            end
            else if (pick < 85)
            begin
                len = $urandom_range(13, 40);
            end
            else if (pick < 97)
            begin
                len = 2;
            end
            else
            begin
                len = $urandom_range(100, 250);
            end
            send_run(len, fill_kind_t'($urandom_range(0, 4)));
            sent += len;
        end
    endtask

    initial
    begin : sink_ctl
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_len != 0)
            begin
                out_stall <= 1'b1;
                repeat (sink_hold_len) @(posedge clk);
                out_stall <= 1'b0;
                sink_hold_len = 0;
            end
            else if (sink_gaps_on && rst_n && $urandom_range(0, 11) == 0)
            begin
                n = $urandom_range(1, 19);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        stats_word_t got;
        stats_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.count = count;
            got.mean = mean;
            got.variance = variance;
            got.stats_valid = stats_valid;
            got.overflow = overflow;
            if (pending_stats.size() == 0)
            begin
                flag_fail($sformatf("unexpected word count=%0d mean=%0d var=%0d",
                                    count, mean, variance));
            end
            else
            begin
                want = pending_stats.pop_front();
                if (got.count !== want.count || got.mean !== want.mean ||
                    got.variance !== want.variance ||
                    got.stats_valid !== want.stats_valid ||
                    got.overflow !== want.overflow)
                begin
                    flag_fail($sformatf(
                        "exp cnt=%0d mean=%0d var=%0d ok=%0b ovf=%0b, got %0d %0d %0d %0b %0b",
                        want.count, want.mean, want.variance, want.stats_valid,
                        want.overflow, got.count, got.mean, got.variance,
                        got.stats_valid, got.overflow));
                end
            end
        end
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** running_mean_sample_variance_core: FAILED **");
        $finish;
    end

    initial
    begin : main_seq
        in_valid <= 1'b0;
        sample <= '0;
        last <= 1'b0;
        rst_n <= 1'b0;
        acc_n = 0;
        acc_sum = 0;
        acc_sq = '0;
        acc_ovf = 1'b0;
        mismatches = 0;
        sink_hold_len = 0;
        src_gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_short_runs();
        test_long_runs();
        test_backpressure();
        test_random_runs(900);
        src_gaps_on = 1'b0;
        sink_gaps_on = 1'b0;
        test_random_runs(250);
        drain_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_stats.size() != 0)
        begin
            flag_fail($sformatf("%0d result words never arrived", pending_stats.size()));
        end
        if (mismatches == 0)
        begin
            $display("** running_mean_sample_variance_core: PASSED **");
        end
        else
        begin
            $display("** running_mean_sample_variance_core: FAILED **");
        end
        $finish;
    end

endmodule

FILE: running_mean_sample_variance_core.f
rtl/core/rmsv_pkg.sv
rtl/core/rmsv_div.sv
rtl/core/rmsv_dp.sv
rtl/core/rmsv_ctrl.sv
rtl/core/running_mean_sample_variance_core.sv
dv/testbench.sv
